// ===== rtl/lcd_4bit_write_sequencer_top_assert.svh =====
// Assertion macros for the LCD 4-bit write sequencer.
`ifndef LCD_4BIT_WRITE_SEQUENCER_TOP_ASSERT_SVH
`define LCD_4BIT_WRITE_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// cond must hold in the same cycle as trig
`define LCD4_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("lcd4 assertion failed");
// cond must hold in the cycle after trig
`define LCD4_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("lcd4 assertion failed");
`else
`define LCD4_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define LCD4_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif
`endif

// ===== rtl/lcd4_pkg.sv =====
// Shared types, codes and the access sequence table of the LCD 4-bit write sequencer.
package lcd4_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned STEP_W      = 4;

  localparam logic [7:0] BIT_E    = 8'h80;
  localparam logic [7:0] BIT_RD   = 8'h40;
  localparam logic [7:0] BIT_RS   = 8'h20;
  localparam logic [7:0] BIT_BUSY = 8'h08;
  localparam logic [7:0] NIB_HI   = 8'hf0;
  localparam logic [7:0] NIB_LO   = 8'h0f;
  localparam logic [7:0] DIR_POLL = 8'hf7;
  localparam logic [7:0] DIR_OUT  = 8'hff;

  typedef enum logic [1:0] {
    CMD_INS_FULL = 2'd0,
    CMD_INS_HIGH = 2'd1,
    CMD_CHAR     = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACC_PORT = 2'd0,
    ACC_DIR  = 2'd1,
    ACC_READ = 2'd2
  } acc_e;

  typedef enum logic [1:0] {
    JOB_POLL      = 2'd0,
    JOB_RETRY     = 2'd1,
    JOB_SEND_FULL = 2'd2,
    JOB_SEND_HIGH = 2'd3
  } job_kind_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] byte_value;
    logic [7:0] port_read;
  } req_t;

  typedef struct packed {
    acc_e       access;
    logic [7:0] port_value;
    logic       last;
  } acc_t;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] data;
    logic       rs;
  } job_t;

  // One port access of a job at a given step.
  function automatic acc_t job_beat(job_t job, logic [STEP_W-1:0] step);
    acc_t       beat;
    logic [7:0] rs;
    logic [7:0] hi;
    logic [7:0] lo;
    beat.access     = ACC_PORT;
    beat.port_value = 8'h00;
    beat.last       = 1'b0;
    rs = job.rs ? BIT_RS : 8'h00;
    hi = ((job.data & NIB_HI) >> 4) | rs;
    lo = (job.data & NIB_LO) | rs;
    case (job.kind)
      JOB_POLL: begin
        case (step)
          4'd0: begin
            beat.access     = ACC_DIR;
            beat.port_value = DIR_POLL;
          end
          4'd1: beat.port_value = BIT_RD;
          4'd2: beat.port_value = BIT_RD | BIT_E;
          default: begin
            beat.access = ACC_READ;
            beat.last   = 1'b1;
          end
        endcase
      end
      JOB_RETRY: begin
        case (step)
          4'd0, 4'd2: beat.port_value = BIT_RD;
          4'd1, 4'd3: beat.port_value = BIT_RD | BIT_E;
          default: begin
            beat.access = ACC_READ;
            beat.last   = 1'b1;
          end
        endcase
      end
      default: begin
        case (step)
          4'd0, 4'd2: beat.port_value = BIT_RD;
          4'd1:       beat.port_value = BIT_RD | BIT_E;
          4'd3: begin
            beat.access     = ACC_DIR;
            beat.port_value = DIR_OUT;
          end
          4'd4: beat.port_value = hi;
          4'd5: beat.port_value = hi | BIT_E;
          4'd6: begin
            beat.port_value = hi;
            beat.last       = (job.kind == JOB_SEND_HIGH);
          end
          4'd7: beat.port_value = lo;
          4'd8: beat.port_value = lo | BIT_E;
          default: begin
            beat.port_value = lo;
            beat.last       = 1'b1;
          end
        endcase
      end
    endcase
    return beat;
  endfunction

endpackage

// ===== rtl/lcd4_stream_if.sv =====
// Valid/ready channel carrying one word of a packed payload type.
interface lcd4_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lcd4_front.sv =====
// Request front end: tracks the busy poll and turns requests into access jobs.
module lcd4_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcd4_stream_if.sink         req_i,
  input  logic                q_ready_i,
  output logic                q_push_o,
  output lcd4_pkg::job_t      q_job_o
);

  logic           polling_q, polling_d;
  logic [7:0]     pending_byte_q, pending_byte_d;
  lcd4_pkg::cmd_e pending_kind_q, pending_kind_d;
  logic           accept;
  logic           is_read;

  assign req_i.ready = q_ready_i;
  assign accept      = req_i.valid && q_ready_i;
  assign is_read     = (req_i.data.command == lcd4_pkg::CMD_READ);

  always_comb begin
    polling_d      = polling_q;
    pending_byte_d = pending_byte_q;
    pending_kind_d = pending_kind_q;
    q_push_o       = 1'b0;
    q_job_o.kind   = lcd4_pkg::JOB_POLL;
    q_job_o.data   = pending_byte_q;
    q_job_o.rs     = (pending_kind_q == lcd4_pkg::CMD_CHAR);
    if (accept) begin
      if (!is_read && !polling_q) begin
        pending_byte_d = req_i.data.byte_value;
        pending_kind_d = req_i.data.command;
        polling_d      = 1'b1;
        q_push_o       = 1'b1;
      end else if (is_read && polling_q) begin
        q_push_o = 1'b1;
        if ((req_i.data.port_read & lcd4_pkg::BIT_BUSY) != 8'h00) begin
          q_job_o.kind = lcd4_pkg::JOB_RETRY;
        end else begin
          polling_d    = 1'b0;
          q_job_o.kind = (pending_kind_q == lcd4_pkg::CMD_INS_HIGH) ?
                         lcd4_pkg::JOB_SEND_HIGH : lcd4_pkg::JOB_SEND_FULL;
        end
      end
      // drop requests during a poll and stray reads
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polling_q      <= 1'b0;
      pending_byte_q <= 8'h00;
      pending_kind_q <= lcd4_pkg::CMD_INS_FULL;
    end else begin
      polling_q      <= polling_d;
      pending_byte_q <= pending_byte_d;
      pending_kind_q <= pending_kind_d;
    end
  end

endmodule

// ===== rtl/lcd4_job_queue.sv =====
// Short job queue between the front end and the access sequencer.
module lcd4_job_queue #(
  parameter int unsigned DEPTH = lcd4_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcd4_pkg::job_t push_job_i,
  output logic           push_ready_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output lcd4_pkg::job_t head_job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  lcd4_pkg::job_t entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lcd4_sequencer.sv =====
// Back end: steps through the port accesses of each job into an output register.
module lcd4_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  lcd4_pkg::job_t head_job_i,
  output logic           pop_o,
  lcd4_stream_if.source  acc_o
);

  logic [lcd4_pkg::STEP_W-1:0] step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  lcd4_pkg::acc_t              out_q;
  lcd4_pkg::acc_t              beat;
  logic                        load;

  assign beat = lcd4_pkg::job_beat(head_job_i, step_q);
  // refill the output word when it is empty or being taken
  assign load = !out_valid_q || acc_o.ready;
  assign pop_o = load && head_valid_i && beat.last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        step_d = beat.last ? '0 : step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      out_q <= beat;
    end
  end

  assign acc_o.valid = out_valid_q;
  assign acc_o.data  = out_q;

endmodule

// ===== rtl/lcd_4bit_write_sequencer_top.sv =====
// Top level of the LCD 4-bit write sequencer: front end, job queue and access sequencer.
//
//   channel  dir  word                               handshake
//   req_i    in   command, byte_value, port_read     valid/ready
//   acc_o    out  access, port_value, last           valid/ready
//
// A request is taken whenever the job queue has room; it yields
// 0, 4, 5, 7 or 10 port-access words, one per cycle while acc_o is ready, from the
// sequencer's output register, so a job's length in words sets the sustained rate.
// Reset clears the poll state, the queue count and the output valid flag at once.
// A stall on acc_o holds the current word; the queue lets requests keep
// arriving until it fills, and then req_i.ready drops.
`include "lcd_4bit_write_sequencer_top_assert.svh"

module lcd_4bit_write_sequencer_top #(
  parameter int unsigned QueueDepth = lcd4_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcd4_stream_if.sink   req_i,
  lcd4_stream_if.source acc_o
);

  logic           q_push;
  logic           q_ready;
  lcd4_pkg::job_t q_job;
  logic           q_pop;
  logic           head_valid;
  lcd4_pkg::job_t head_job;

  lcd4_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_job_o   (q_job)
  );

  lcd4_job_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_job_i   (q_job),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  lcd4_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (q_pop),
    .acc_o        (acc_o)
  );

  `LCD4_ASSERT_SAME(a_push_has_room, clk_i, rst_ni, q_push, q_ready)
  `LCD4_ASSERT_SAME(a_pop_has_head, clk_i, rst_ni, q_pop, head_valid)
  `LCD4_ASSERT_SAME(a_read_ends_job, clk_i, rst_ni,
    acc_o.valid && acc_o.data.access == lcd4_pkg::ACC_READ, acc_o.data.last)
  `LCD4_ASSERT_SAME(a_dir_values, clk_i, rst_ni,
    acc_o.valid && acc_o.data.access == lcd4_pkg::ACC_DIR,
    acc_o.data.port_value == lcd4_pkg::DIR_POLL || acc_o.data.port_value == lcd4_pkg::DIR_OUT)

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the LCD 4-bit write sequencer: directed table, random polls, predictor check.
`timescale 1ns / 100ps

module tb;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_POLL,
    CHK_BUSY
  } check_e;

  typedef struct {
    lcd4_pkg::req_t req;
    check_e         chk;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lcd4_stream_if #(.T(lcd4_pkg::req_t)) req_if ();
  lcd4_stream_if #(.T(lcd4_pkg::acc_t)) acc_if ();

  lcd_4bit_write_sequencer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .acc_o  (acc_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic           poll_active = 1'b0;
  logic [7:0]     held_byte = 8'h00;
  lcd4_pkg::cmd_e held_kind = lcd4_pkg::CMD_INS_FULL;

  lcd4_pkg::acc_t step_words[$];
  lcd4_pkg::acc_t port_access_q[$];
  dir_row_t       dir_rows[$];
  lcd4_pkg::acc_t want_word;

  int  fail_count = 0;
  int  items_sent = 0;
  int  active_items = 0;
  int  stall_left = 0;
  bit  hold_done = 1'b0;
  bit  steady_flow = 1'b0;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void put_word(lcd4_pkg::acc_e acc, logic [7:0] val);
    lcd4_pkg::acc_t w;
    w.access     = acc;
    w.port_value = val;
    w.last       = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void put_nibble(logic [7:0] nib);
    put_word(lcd4_pkg::ACC_PORT, nib);
    put_word(lcd4_pkg::ACC_PORT, nib | lcd4_pkg::BIT_E);
    put_word(lcd4_pkg::ACC_PORT, nib);
  endfunction

  // Port accesses that one request causes; advances the poll state.
  function automatic void predict_accesses(lcd4_pkg::req_t r);
    logic [7:0] rs;
    step_words.delete();
    if (r.command != lcd4_pkg::CMD_READ) begin
      if (poll_active) return;
      held_byte   = r.byte_value;
      held_kind   = r.command;
      poll_active = 1'b1;
      put_word(lcd4_pkg::ACC_DIR, lcd4_pkg::DIR_POLL);
      put_word(lcd4_pkg::ACC_PORT, lcd4_pkg::BIT_RD);
      put_word(lcd4_pkg::ACC_PORT, lcd4_pkg::BIT_RD | lcd4_pkg::BIT_E);
      put_word(lcd4_pkg::ACC_READ, 8'h00);
    end else begin
      if (!poll_active) return;
      put_word(lcd4_pkg::ACC_PORT, lcd4_pkg::BIT_RD);
      put_word(lcd4_pkg::ACC_PORT, lcd4_pkg::BIT_RD | lcd4_pkg::BIT_E);
      if ((r.port_read & lcd4_pkg::BIT_BUSY) != 8'h00) begin
        put_word(lcd4_pkg::ACC_PORT, lcd4_pkg::BIT_RD);
        put_word(lcd4_pkg::ACC_PORT, lcd4_pkg::BIT_RD | lcd4_pkg::BIT_E);
        put_word(lcd4_pkg::ACC_READ, 8'h00);
      end else begin
        rs = (held_kind == lcd4_pkg::CMD_CHAR) ? lcd4_pkg::BIT_RS : 8'h00;
        poll_active = 1'b0;
        put_word(lcd4_pkg::ACC_PORT, lcd4_pkg::BIT_RD);
        put_word(lcd4_pkg::ACC_DIR, lcd4_pkg::DIR_OUT);
        put_nibble(((held_byte & lcd4_pkg::NIB_HI) >> 4) | rs);
        if (held_kind != lcd4_pkg::CMD_INS_HIGH) begin
          put_nibble((held_byte & lcd4_pkg::NIB_LO) | rs);
        end
      end
    end
    step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  // Offer one word, wait for the handshake, then queue what it should cause.
  task automatic send_word(input lcd4_pkg::req_t r, input check_e chk);
    int gap;
    gap = (steady_flow || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    predict_accesses(r);
    case (chk)
      CHK_NONE: step_words.delete();
      CHK_POLL: begin
        step_words.delete();
        put_word(lcd4_pkg::ACC_DIR, lcd4_pkg::DIR_POLL);
        put_word(lcd4_pkg::ACC_PORT, 8'h40);
        put_word(lcd4_pkg::ACC_PORT, 8'hc0);
        put_word(lcd4_pkg::ACC_READ, 8'h00);
      end
      CHK_BUSY: begin
        step_words.delete();
        put_word(lcd4_pkg::ACC_PORT, 8'h40);
        put_word(lcd4_pkg::ACC_PORT, 8'hc0);
        put_word(lcd4_pkg::ACC_PORT, 8'h40);
        put_word(lcd4_pkg::ACC_PORT, 8'hc0);
        put_word(lcd4_pkg::ACC_READ, 8'h00);
      end
      default: ;
    endcase
    if (chk == CHK_POLL || chk == CHK_BUSY) step_words[step_words.size() - 1].last = 1'b1;
    if (step_words.size() != 0) active_items++;
    items_sent++;
    foreach (step_words[i]) port_access_q.push_back(step_words[i]);
  endtask

  function automatic void add_row(lcd4_pkg::cmd_e cmd, logic [7:0] val, logic [7:0] rd,
                                  check_e chk);
    dir_row_t row;
    row.req.command    = cmd;
    row.req.byte_value = val;
    row.req.port_read  = rd;
    row.chk            = chk;
    dir_rows.push_back(row);
  endfunction

  // Receiver: random stalls, one long hold-off once the random part is under way.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      acc_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      acc_if.ready <= 1'b0;
      stall_left--;
    end else if (!hold_done && items_sent >= 60) begin
      hold_done    = 1'b1;
      stall_left   = 399;
      acc_if.ready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      stall_left   = pick_gap() - 1;
      acc_if.ready <= 1'b0;
    end else begin
      acc_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && acc_if.valid && acc_if.ready) begin
      if (port_access_q.size() == 0) begin
        $error("word with no expectation: access %0d port_value %02h last %0b",
               acc_if.data.access, acc_if.data.port_value, acc_if.data.last);
        fail_count++;
      end else begin
        want_word = port_access_q.pop_front();
        if (acc_if.data.access !== want_word.access) begin
          $error("access: expected %0d, got %0d", want_word.access, acc_if.data.access);
          fail_count++;
        end
        if (acc_if.data.port_value !== want_word.port_value) begin
          $error("port_value: expected %02h, got %02h",
                 want_word.port_value, acc_if.data.port_value);
          fail_count++;
        end
        if (acc_if.data.last !== want_word.last) begin
          $error("last: expected %0b, got %0b", want_word.last, acc_if.data.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    lcd4_pkg::req_t r;
    int             busy_n;
    bit             paused;
    paused       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;

    // stray reads, requests while polling, busy flag set and clear, every kind at the extremes
    add_row(lcd4_pkg::CMD_READ,     8'h00, 8'hff, CHK_NONE);
    add_row(lcd4_pkg::CMD_INS_FULL, 8'h00, 8'hff, CHK_POLL);
    add_row(lcd4_pkg::CMD_INS_FULL, 8'hff, 8'h00, CHK_NONE);
    add_row(lcd4_pkg::CMD_CHAR,     8'ha5, 8'h5a, CHK_NONE);
    add_row(lcd4_pkg::CMD_READ,     8'hff, 8'h08, CHK_BUSY);
    add_row(lcd4_pkg::CMD_READ,     8'h00, 8'hff, CHK_BUSY);
    add_row(lcd4_pkg::CMD_READ,     8'hff, 8'hf7, CHK_PREDICT);
    add_row(lcd4_pkg::CMD_READ,     8'hff, 8'h00, CHK_NONE);
    add_row(lcd4_pkg::CMD_INS_FULL, 8'hff, 8'hff, CHK_POLL);
    add_row(lcd4_pkg::CMD_READ,     8'h00, 8'h00, CHK_PREDICT);
    add_row(lcd4_pkg::CMD_INS_HIGH, 8'hff, 8'h00, CHK_POLL);
    add_row(lcd4_pkg::CMD_READ,     8'hff, 8'h00, CHK_PREDICT);
    add_row(lcd4_pkg::CMD_INS_HIGH, 8'h00, 8'hff, CHK_POLL);
    add_row(lcd4_pkg::CMD_INS_HIGH, 8'h5a, 8'ha5, CHK_NONE);
    add_row(lcd4_pkg::CMD_READ,     8'h00, 8'h37, CHK_PREDICT);
    add_row(lcd4_pkg::CMD_CHAR,     8'hff, 8'h08, CHK_POLL);
    add_row(lcd4_pkg::CMD_READ,     8'h00, 8'h08, CHK_BUSY);
    add_row(lcd4_pkg::CMD_READ,     8'h00, 8'hf7, CHK_PREDICT);
    add_row(lcd4_pkg::CMD_CHAR,     8'h00, 8'h00, CHK_POLL);
    add_row(lcd4_pkg::CMD_READ,     8'h00, 8'h00, CHK_PREDICT);
    add_row(lcd4_pkg::CMD_CHAR,     8'h5a, 8'h00, CHK_POLL);
    add_row(lcd4_pkg::CMD_READ,     8'h00, 8'ha5, CHK_PREDICT);
    add_row(lcd4_pkg::CMD_INS_FULL, 8'h3c, 8'h00, CHK_POLL);
    add_row(lcd4_pkg::CMD_READ,     8'hc3, 8'h3c, CHK_BUSY);
    add_row(lcd4_pkg::CMD_READ,     8'h3c, 8'hc3, CHK_PREDICT);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].req, dir_rows[i].chk);

    // Mostly well-formed polls: request, a few busy reads, then a clear read.
    while (active_items < 230) begin
      steady_flow = (active_items >= 90 && active_items < 130);
      if (!paused && active_items >= 150) begin
        paused = 1'b1;
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        while (port_access_q.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 9) == 0) begin
        r.command    = lcd4_pkg::cmd_e'($urandom_range(0, 3));
        r.byte_value = 8'($urandom);
        r.port_read  = 8'($urandom);
        send_word(r, CHK_PREDICT);
      end else begin
        r.command    = lcd4_pkg::cmd_e'($urandom_range(0, 2));
        r.byte_value = 8'($urandom);
        r.port_read  = 8'($urandom);
        send_word(r, CHK_PREDICT);
        busy_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (busy_n) begin
          if ($urandom_range(0, 7) == 0) begin
            r.command    = lcd4_pkg::cmd_e'($urandom_range(0, 2));
            r.byte_value = 8'($urandom);
            r.port_read  = 8'($urandom);
            send_word(r, CHK_PREDICT);
          end
          r.command    = lcd4_pkg::CMD_READ;
          r.byte_value = 8'($urandom);
          r.port_read  = 8'($urandom | lcd4_pkg::BIT_BUSY);
          send_word(r, CHK_PREDICT);
        end
        r.command    = lcd4_pkg::CMD_READ;
        r.byte_value = 8'($urandom);
        r.port_read  = 8'($urandom & ~lcd4_pkg::BIT_BUSY);
        send_word(r, CHK_PREDICT);
      end
    end
    steady_flow = 1'b0;

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (port_access_q.size() != 0) @(negedge clk_i);
    // drain: catch any extra word the block still puts out
    repeat (40) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lcd4_pkg.sv
rtl/lcd4_stream_if.sv
rtl/lcd4_front.sv
rtl/lcd4_job_queue.sv
rtl/lcd4_sequencer.sv
rtl/lcd_4bit_write_sequencer_top.sv
tb/sv/tb.sv
